// ===== hw/rtl/fbdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbdt_pkg
// Shared constants, payload types and controller/datapath command types.
// ----------------------------------------------------------------------------
package fbdt_pkg;

   localparam int CANVAS_WIDTH  = 320;
   localparam int CANVAS_HEIGHT = 240;
   localparam int GLYPH_BYTES   = 4096;
   localparam int CANVAS_DEPTH  = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int CANVAS_AW     = $clog2(CANVAS_DEPTH);
   localparam int GLYPH_AW      = $clog2(GLYPH_BYTES);

   localparam logic [2:0] CMD_FILL  = 3'd0;
   localparam logic [2:0] CMD_RECT  = 3'd1;
   localparam logic [2:0] CMD_PIXEL = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_GLOAD = 3'd4;
   localparam logic [2:0] CMD_TEXT  = 3'd5;
   localparam logic [2:0] CMD_CHAR  = 3'd6;
   localparam logic [2:0] CMD_NONE  = 3'd7;

   localparam logic CSR_FONT_WIDTH  = 1'b0;
   localparam logic CSR_FONT_HEIGHT = 1'b1;

   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   typedef struct packed {
      logic [2:0]  command;
      logic [8:0]  x_start;
      logic [7:0]  y_start;
      logic [8:0]  x_end;
      logic [7:0]  y_end;
      logic [15:0] color;
      logic [7:0]  character;
      logic [11:0] glyph_address;
      logic [7:0]  glyph_data;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_value;
      logic [8:0]  text_col;
      logic [7:0]  text_row;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR_STEP,
      OP_FILL_STEP,
      OP_XY_INIT,
      OP_ROW,
      OP_RECT_STEP,
      OP_PIX_WRITE,
      OP_READ_ISSUE,
      OP_READ_CAP,
      OP_CHAR_PREP,
      OP_CHAR_BASE,
      OP_GLYPH_READ,
      OP_GLYPH_BIT
   } dp_op_type;

   typedef struct packed {
      logic [2:0] command;
      logic       sweep_last;
      logic       rect_empty;
      logic       x_last;
      logic       y_last;
      logic       draw_en;
      logic       bit_last;
      logic       byte_last;
      logic       row_last;
   } dp_status_type;

endpackage

// ===== hw/rtl/fbdt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbdt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/fbdt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbdt_dp
// Datapath: canvas and glyph memories, scan counters, cursor and region state.
// ----------------------------------------------------------------------------
module fbdt_dp import fbdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_op_type     op,
   input  req_type       req_i,
   input  logic          csr_write,
   input  logic          csr_index,
   input  logic [5:0]    csr_data,
   output dp_status_type status,
   output rsp_type       rsp_o
);

   req_type                req_ff;
   logic [4:0]             fw_ff;
   logic [5:0]             fh_ff;
   logic [8:0]             cur_x_ff, reg_l_ff, reg_r_ff;
   logic [7:0]             cur_y_ff, reg_t_ff, reg_b_ff;
   logic [CANVAS_AW-1:0]   lin_ff, ybase_ff;
   logic [9:0]             x_ff, y_ff;
   logic [8:0]             x0_ff;
   logic [13:0]            m1_ff;
   logic [16:0]            gaddr_ff;
   logic                   gvalid_ff;
   logic [2:0]             bit_ff;
   logic [1:0]             bx_ff;
   logic [5:0]             row_ff;
   logic [15:0]            pix_ff;

   logic [15:0]            word;
   logic [9:0]             xe_c;
   logic [8:0]             ye_c;
   logic                   in_canvas;
   logic [2:0]             bpr;
   logic                   nl, wrap, bot;
   logic [8:0]             cx1, cx2, cy1, cy2;
   logic                   c_we, c_re, g_re, g_bit;
   logic [CANVAS_AW-1:0]   c_waddr, xy_addr;
   logic [15:0]            c_wdata, c_rdata;
   logic [7:0]             g_rdata;

   assign word      = {req_ff.color[7:0], req_ff.color[15:8]};
   assign xe_c      = ({1'b0, req_ff.x_end} > 10'(CANVAS_WIDTH)) ?
                      10'(CANVAS_WIDTH) : {1'b0, req_ff.x_end};
   assign ye_c      = ({1'b0, req_ff.y_end} > 9'(CANVAS_HEIGHT)) ?
                      9'(CANVAS_HEIGHT) : {1'b0, req_ff.y_end};
   assign in_canvas = (x_ff < 10'(CANVAS_WIDTH)) && (y_ff < 10'(CANVAS_HEIGHT));
   assign bpr       = 3'((6'(fw_ff) + 6'd7) >> 3);
   assign xy_addr   = CANVAS_AW'(ybase_ff + CANVAS_AW'(x_ff));
   assign g_bit     = gvalid_ff & g_rdata[3'd7 - bit_ff];

   assign nl   = (req_ff.character == NEWLINE_CODE);
   assign wrap = ((10'(cur_x_ff) + 10'(fw_ff)) >= 10'(reg_r_ff)) || nl;
   assign cx1  = wrap ? reg_l_ff : cur_x_ff;
   assign cy1  = wrap ? (9'(cur_y_ff) + 9'(fh_ff)) : 9'(cur_y_ff);
   assign bot  = (10'(cy1) + 10'(fh_ff)) >= 10'(reg_b_ff);
   assign cx2  = bot ? reg_l_ff : cx1;
   assign cy2  = bot ? 9'(reg_t_ff) : cy1;

   always_comb begin
      c_we    = 1'b0;
      c_waddr = xy_addr;
      c_wdata = word;
      case (op)
         OP_CLEAR_STEP: begin
            c_we    = 1'b1;
            c_waddr = lin_ff;
            c_wdata = '0;
         end
         OP_FILL_STEP: begin
            c_we    = 1'b1;
            c_waddr = lin_ff;
         end
         OP_RECT_STEP, OP_PIX_WRITE: c_we = in_canvas;
         OP_GLYPH_BIT:               c_we = in_canvas & g_bit;
         default:                    c_we = 1'b0;
      endcase
   end

   assign c_re = (op == OP_READ_ISSUE);
   assign g_re = (op == OP_GLYPH_READ);

   fbdt_ram #(.WIDTH(16), .DEPTH(CANVAS_DEPTH)) u_canvas (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_en   (c_re),
      .rd_addr (xy_addr),
      .rd_data (c_rdata)
   );

   fbdt_ram #(.WIDTH(8), .DEPTH(GLYPH_BYTES)) u_glyph (
      .clock   (clock),
      .wr_en   ((op == OP_LOAD) && (req_i.command == CMD_GLOAD) &&
                (13'(req_i.glyph_address) < 13'(GLYPH_BYTES))),
      .wr_addr (GLYPH_AW'(req_i.glyph_address)),
      .wr_data (req_i.glyph_data),
      .rd_en   (g_re),
      .rd_addr (GLYPH_AW'(gaddr_ff)),
      .rd_data (g_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff    <= 5'd8;
         fh_ff    <= 6'd8;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         reg_l_ff <= '0;
         reg_t_ff <= '0;
         reg_r_ff <= 9'(CANVAS_WIDTH);
         reg_b_ff <= 8'(CANVAS_HEIGHT);
         lin_ff   <= '0;
         pix_ff   <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_FONT_WIDTH) begin
               fw_ff <= csr_data[4:0];
            end else begin
               fh_ff <= csr_data;
            end
         end
         case (op)
            OP_LOAD: begin
               req_ff <= req_i;
               pix_ff <= '0;
               if (req_i.command == CMD_TEXT) begin
                  reg_l_ff <= req_i.x_start;
                  reg_t_ff <= req_i.y_start;
                  reg_r_ff <= req_i.x_end;
                  reg_b_ff <= req_i.y_end;
                  cur_x_ff <= req_i.x_start;
                  cur_y_ff <= req_i.y_start;
               end
            end
            OP_CLEAR_STEP, OP_FILL_STEP: begin
               lin_ff <= (lin_ff == CANVAS_AW'(CANVAS_DEPTH - 1)) ? '0 : lin_ff + 1'b1;
            end
            OP_XY_INIT: begin
               x_ff <= 10'(req_ff.x_start);
               y_ff <= 10'(req_ff.y_start);
            end
            OP_ROW: ybase_ff <= CANVAS_AW'(y_ff) * CANVAS_AW'(CANVAS_WIDTH);
            OP_RECT_STEP: begin
               if (status.x_last) begin
                  x_ff <= 10'(req_ff.x_start);
                  y_ff <= y_ff + 1'b1;
               end else begin
                  x_ff <= x_ff + 1'b1;
               end
            end
            OP_READ_CAP: pix_ff <= in_canvas ? c_rdata : '0;
            OP_CHAR_PREP: begin
               x_ff     <= 10'(cx2);
               x0_ff    <= cx2;
               y_ff     <= 10'(cy2);
               cur_x_ff <= nl ? cx2 : 9'(cx2 + 9'(fw_ff));
               cur_y_ff <= cy2[7:0];
               m1_ff    <= 14'(req_ff.character - SPACE_CODE) * 14'(fh_ff);
            end
            OP_CHAR_BASE: begin
               gaddr_ff <= 17'(m1_ff) * 17'(bpr);
               row_ff   <= '0;
               bx_ff    <= '0;
            end
            OP_GLYPH_READ: begin
               gvalid_ff <= gaddr_ff < 17'(GLYPH_BYTES);
               gaddr_ff  <= gaddr_ff + 1'b1;
               bit_ff    <= '0;
            end
            OP_GLYPH_BIT: begin
               bit_ff <= bit_ff + 1'b1;
               if (status.bit_last && status.byte_last) begin
                  x_ff   <= 10'(x0_ff);
                  y_ff   <= y_ff + 1'b1;
                  bx_ff  <= '0;
                  row_ff <= row_ff + 1'b1;
               end else begin
                  x_ff <= x_ff + 1'b1;
                  if (status.bit_last) begin
                     bx_ff <= bx_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      status.command    = req_ff.command;
      status.sweep_last = (lin_ff == CANVAS_AW'(CANVAS_DEPTH - 1));
      status.rect_empty = (10'(req_ff.x_start) >= xe_c) || (9'(req_ff.y_start) >= ye_c);
      status.x_last     = (11'(x_ff) + 11'd1) >= 11'(xe_c);
      status.y_last     = (11'(y_ff) + 11'd1) >= 11'(ye_c);
      status.draw_en    = (req_ff.character >= SPACE_CODE) && (fw_ff != '0) &&
                          (fh_ff != '0);
      status.bit_last   = (bit_ff == 3'd7);
      status.byte_last  = (3'(bx_ff) == (bpr - 3'd1));
      status.row_last   = (row_ff == (fh_ff - 6'd1));
   end

   assign rsp_o.pixel_value = pix_ff;
   assign rsp_o.text_col    = cur_x_ff;
   assign rsp_o.text_row    = cur_y_ff;

endmodule

// ===== hw/rtl/fbdt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbdt_ctrl
// Command sequencer: clear pass, dispatch, scan loops and response handshake.
// ----------------------------------------------------------------------------
module fbdt_ctrl import fbdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_op_type     op
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_FILL, S_RECT_ROW, S_RECT_RUN,
      S_PIX_ROW, S_PIX_WR, S_RD_ROW, S_RD_ISSUE, S_RD_CAP,
      S_CHAR_BASE, S_CHAR_ROW, S_GREAD, S_GBITS, S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            op = OP_CLEAR_STEP;
            if (status.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.command)
               CMD_FILL: state_in = S_FILL;
               CMD_RECT: begin
                  op       = OP_XY_INIT;
                  state_in = status.rect_empty ? S_RESP : S_RECT_ROW;
               end
               CMD_PIXEL: begin
                  op       = OP_XY_INIT;
                  state_in = S_PIX_ROW;
               end
               CMD_READ: begin
                  op       = OP_XY_INIT;
                  state_in = S_RD_ROW;
               end
               CMD_CHAR: begin
                  op       = OP_CHAR_PREP;
                  state_in = status.draw_en ? S_CHAR_BASE : S_RESP;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_FILL: begin
            op = OP_FILL_STEP;
            if (status.sweep_last) state_in = S_RESP;
         end
         S_RECT_ROW: begin
            op       = OP_ROW;
            state_in = S_RECT_RUN;
         end
         S_RECT_RUN: begin
            op = OP_RECT_STEP;
            if (status.x_last) state_in = status.y_last ? S_RESP : S_RECT_ROW;
         end
         S_PIX_ROW: begin
            op       = OP_ROW;
            state_in = S_PIX_WR;
         end
         S_PIX_WR: begin
            op       = OP_PIX_WRITE;
            state_in = S_RESP;
         end
         S_RD_ROW: begin
            op       = OP_ROW;
            state_in = S_RD_ISSUE;
         end
         S_RD_ISSUE: begin
            op       = OP_READ_ISSUE;
            state_in = S_RD_CAP;
         end
         S_RD_CAP: begin
            op       = OP_READ_CAP;
            state_in = S_RESP;
         end
         S_CHAR_BASE: begin
            op       = OP_CHAR_BASE;
            state_in = S_CHAR_ROW;
         end
         S_CHAR_ROW: begin
            op       = OP_ROW;
            state_in = S_GREAD;
         end
         S_GREAD: begin
            op       = OP_GLYPH_READ;
            state_in = S_GBITS;
         end
         S_GBITS: begin
            op = OP_GLYPH_BIT;
            if (status.bit_last) begin
               if (!status.byte_last)     state_in = S_GREAD;
               else if (status.row_last)  state_in = S_RESP;
               else                       state_in = S_CHAR_ROW;
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

`ifndef SYNTH
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready and response valid at once");
   a_one: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transfer accepted before response");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");
`endif

endmodule

// ===== hw/rtl/framebuffer_draw_and_text_engine_unit.sv =====
`timescale 1ns / 1ps
// Sequencing: fill sweeps the whole canvas; rectangle, pixel and read set up each row first;
//   a character reads each glyph byte, then draws its bits; bound by one canvas write/cycle.
// Throughput: one command at a time; next transfer taken after the response transfer.
// Reset: synchronous; a clearing pass then zeroes the whole canvas, with req_ready low.
// ----------------------------------------------------------------------------
// framebuffer_draw_and_text_engine_unit
// Canvas drawing and bitmap text engine, top level.
// ----------------------------------------------------------------------------
module framebuffer_draw_and_text_engine_unit import fbdt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [5:0] csr_data
);

   dp_op_type     op;
   dp_status_type status;

   fbdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .op        (op)
   );

   fbdt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_i     (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .status    (status),
      .rsp_o     (rsp_data)
   );

endmodule
